/* rtl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, codes and controller/datapath bundles for the RPN
// stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int QUO_W       = DATA_W + FRAC_W;
  localparam int DIV_STEPS   = QUO_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  // Token kinds.
  localparam logic [2:0] KIND_PUSH = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_SUB  = 3'd2;
  localparam logic [2:0] KIND_MUL  = 3'd3;
  localparam logic [2:0] KIND_DIV  = 3'd4;
  localparam logic [2:0] KIND_REM  = 3'd5;

  // Error codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;
  localparam logic [1:0] ERR_DIVZ  = 2'd3;

  typedef struct packed {
    logic load;      // capture the token
    logic push_in;   // push the token's number
    logic pop_b;     // pop the right operand
    logic pop_a;     // pop the left operand
    logic drop_b;    // zero divisor: leave b popped, expose the new top
    logic addsub;    // saturated add or subtract
    logic mul;       // register the full product
    logic mul_fix;   // scale and saturate the product
    logic div_init;  // load the shared divider
    logic div_step;  // one restoring step
    logic div_fix;   // sign and saturate the quotient, or sign the remainder
    logic push_res;  // push the result
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       div_zero;
    logic       div_last;
  } status_t;

endpackage

`default_nettype wire

/* rtl/rpn_ram.sv */
// ----------------------------------------------------------------------------
// rpn_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/rpn_datapath.sv */
// ----------------------------------------------------------------------------
// rpn_datapath
// Operand stack (RAM plus a top-of-stack register), operand registers,
// adder, multiplier and a shared radix-2 restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_datapath
  import rpn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] operand_value,
  output status_t          status,
  output logic [31:0]      top_value,
  output logic [7:0]       stack_depth,
  output logic [1:0]       error_code
);

  logic [PTR_W-1:0]  stack_ptr;
  logic [1:0]        err;
  logic [2:0]        kind_q;
  logic [DATA_W-1:0] opv;
  logic [DATA_W-1:0] top;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] res;
  logic signed [2*DATA_W-1:0] prod;

  logic [QUO_W-1:0]  quo;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;

  logic              stack_full;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  logic [16:0]       ia;
  logic [16:0]       ib;
  logic [16:0]       ia_mag;
  logic [16:0]       ib_mag;
  logic [DATA_W-1:0] a_mag;
  logic [DATA_W-1:0] b_mag;

  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] sum_sat;
  logic [QUO_W-1:0]  scaled;
  logic [DATA_W-1:0] mul_sat;
  logic [DATA_W-1:0] div_res;
  logic [DATA_W-1:0] rem_val;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_diff;
  logic              rem_ge;

  assign stack_full = (stack_ptr >= PTR_W'(STACK_DEPTH));

  // The stack RAM holds every entry; top mirrors the entry at stack_ptr - 1.
  assign ram_we    = (cmd.push_in && !stack_full) || cmd.push_res;
  assign ram_waddr = ADDR_W'(stack_ptr);
  assign ram_wdata = cmd.push_res ? res : opv;
  assign ram_raddr = ADDR_W'(stack_ptr - PTR_W'(2));

  rpn_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Integer parts, truncated toward zero.
  always_comb begin
    ia = {a[31], a[31:16]} + {16'b0, a[31] && (a[15:0] != 16'b0)};
    ib = {b[31], b[31:16]} + {16'b0, b[31] && (b[15:0] != 16'b0)};
    ia_mag = ia[16] ? (~ia + 17'd1) : ia;
    ib_mag = ib[16] ? (~ib + 17'd1) : ib;
    a_mag  = a[31] ? (~a + 32'd1) : a;
    b_mag  = b[31] ? (~b + 32'd1) : b;
  end

  always_comb begin
    if (kind_q == KIND_SUB) begin
      sum = {a[31], a} - {b[31], b};
    end else begin
      sum = {a[31], a} + {b[31], b};
    end
    if (sum[32] != sum[31]) begin
      sum_sat = sum[32] ? Q_MIN : Q_MAX;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // Product scaled by 2^-16 with truncation toward zero.
  always_comb begin
    scaled = prod[63:16] + {47'b0, prod[63] && (prod[15:0] != 16'b0)};
    if (scaled[47:31] != {17{scaled[47]}}) begin
      mul_sat = scaled[47] ? Q_MIN : Q_MAX;
    end else begin
      mul_sat = scaled[31:0];
    end
  end

  always_comb begin
    rem_sh   = {rem_r, quo[QUO_W-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    rem_ge   = (rem_sh >= {1'b0, dvs});
  end

  always_comb begin
    if (a[31] ^ b[31]) begin
      div_res = (quo > QUO_W'(Q_MIN)) ? Q_MIN : (~quo[31:0] + 32'd1);
    end else begin
      div_res = (quo > QUO_W'(Q_MAX)) ? Q_MAX : quo[31:0];
    end
    // The remainder carries the sign of the left operand.
    rem_val = {rem_r[15:0], 16'b0};
    if (a[31]) begin
      rem_val = ~rem_val + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_ptr <= '0;
      err       <= ERR_NONE;
      kind_q    <= KIND_PUSH;
    end else begin
      if (cmd.load) begin
        kind_q <= kind;
        err    <= ERR_NONE;
      end
      if (cmd.push_in) begin
        if (stack_full) begin
          err <= ERR_FULL;
        end else begin
          stack_ptr <= stack_ptr + PTR_W'(1);
        end
      end
      if (cmd.pop_b || cmd.pop_a) begin
        if (stack_ptr != '0) begin
          stack_ptr <= stack_ptr - PTR_W'(1);
        end else begin
          err <= ERR_EMPTY;
        end
      end
      if (cmd.drop_b) begin
        err <= ERR_DIVZ;
      end
      if (cmd.push_res) begin
        stack_ptr <= stack_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opv <= operand_value;
    end
    if (cmd.push_in && !stack_full) begin
      top <= opv;
    end
    if (cmd.pop_b) begin
      b <= (stack_ptr != '0) ? top : '0;
    end
    if (cmd.pop_a) begin
      a <= (stack_ptr != '0) ? ram_rdata : '0;
    end
    if (cmd.drop_b) begin
      top <= ram_rdata;
    end
    if (cmd.addsub) begin
      res <= sum_sat;
    end
    if (cmd.mul) begin
      prod <= $signed(a) * $signed(b);
    end
    if (cmd.mul_fix) begin
      res <= mul_sat;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      cnt   <= CNT_W'(DIV_STEPS - 1);
      if (kind_q == KIND_REM) begin
        quo <= QUO_W'(ia_mag);
        dvs <= DATA_W'(ib_mag);
      end else begin
        quo <= {a_mag, {FRAC_W{1'b0}}};
        dvs <= b_mag;
      end
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo   <= {quo[QUO_W-2:0], rem_ge};
      cnt   <= cnt - CNT_W'(1);
    end
    if (cmd.div_fix) begin
      res <= (kind_q == KIND_REM) ? rem_val : div_res;
    end
    if (cmd.push_res) begin
      top <= res;
    end
  end

  always_comb begin
    status.kind     = kind_q;
    status.div_zero = ((kind_q == KIND_DIV) && (b == '0)) ||
                      ((kind_q == KIND_REM) && (ib == '0));
    status.div_last = (cnt == '0);
  end

  assign top_value   = (stack_ptr != '0) ? top : '0;
  assign stack_depth = 8'(stack_ptr);
  assign error_code  = err;

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    stack_ptr <= PTR_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push_res |-> !stack_full)
    else $error("result pushed onto a full stack");

  a_pop_order: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_a |-> $past(cmd.pop_b))
    else $error("left operand popped without the read set up by the right pop");

endmodule

`default_nettype wire

/* rtl/rpn_ctrl.sv */
// ----------------------------------------------------------------------------
// rpn_ctrl
// Sequencer for the RPN evaluator: decodes each token and steps the
// datapath through pops, the arithmetic and the final push.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ctrl
  import rpn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [2:0] kind,
  input  wire status_t    status,
  output cmd_t            cmd,
  output logic            busy,
  output logic            done
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_PUSH     = 12'b0000_0000_0010,
    S_POP_B    = 12'b0000_0000_0100,
    S_POP_A    = 12'b0000_0000_1000,
    S_ADDSUB   = 12'b0000_0001_0000,
    S_MUL      = 12'b0000_0010_0000,
    S_MUL_FIX  = 12'b0000_0100_0000,
    S_DIV_INIT = 12'b0000_1000_0000,
    S_DIV_RUN  = 12'b0001_0000_0000,
    S_DIV_FIX  = 12'b0010_0000_0000,
    S_PUSH_RES = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (kind)
            KIND_PUSH: state_next = S_PUSH;
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_REM: state_next = S_POP_B;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_PUSH: begin
        cmd.push_in = 1'b1;
        state_next  = S_DONE;
      end
      S_POP_B: begin
        cmd.pop_b  = 1'b1;
        state_next = S_POP_A;
      end
      S_POP_A: begin
        // A zero divisor ends the token with only the right operand popped.
        if (status.div_zero) begin
          cmd.drop_b = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.pop_a = 1'b1;
          case (status.kind)
            KIND_ADD, KIND_SUB: state_next = S_ADDSUB;
            KIND_MUL:           state_next = S_MUL;
            KIND_DIV, KIND_REM: state_next = S_DIV_INIT;
            default:            state_next = S_DONE;
          endcase
        end
      end
      S_ADDSUB: begin
        cmd.addsub = 1'b1;
        state_next = S_PUSH_RES;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_MUL_FIX;
      end
      S_MUL_FIX: begin
        cmd.mul_fix = 1'b1;
        state_next  = S_PUSH_RES;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DIV_FIX;
        end
      end
      S_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = S_PUSH_RES;
      end
      S_PUSH_RES: begin
        cmd.push_res = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted token did not make the block busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  a_push_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.push_res |=> done)
    else $error("pushed result not reported in the next cycle");

endmodule

`default_nettype wire

/* rtl/rpn_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse-Polish calculator on Q16.16 numbers with a 128-entry operand stack.
// ----------------------------------------------------------------------------
// Usage: drive kind and operand_value with start high while busy is low; the
// token is taken at that clock edge. kind 0 pushes operand_value, 1 to 5 apply
// add, subtract, multiply, divide or remainder to the top two entries (the
// top entry is the right operand). Every token gives exactly one result beat:
// done is high for one cycle with top_value, stack_depth and error_code
// valid, and the beat is taken at the edge that ends that cycle. The receiver
// cannot hold it off; done then drops and busy falls in the next cycle.
// Unused kinds go straight to done and push writes the stack; an operator pops
// the right and then the left operand, computes (multiply registers the full
// product before scaling it) and pushes the result; a zero divisor ends the
// token after the right pop. The next token is accepted once busy falls. The
// 48 steps of the shared radix-2 divider make a divide or remainder that runs
// it the slowest token; every token waits for the stack the previous one left.
// Reset (synchronous, active high) empties the stack and returns to idle; the
// stack memory itself is not cleared, as only entries below the depth are read.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator
  import rpn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] operand_value,
  output logic             done,
  output logic [31:0]      top_value,
  output logic [7:0]       stack_depth,
  output logic [1:0]       error_code
);

  cmd_t    cmd;
  status_t status;

  rpn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  rpn_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (kind),
    .operand_value(operand_value),
    .status       (status),
    .top_value    (top_value),
    .stack_depth  (stack_depth),
    .error_code   (error_code)
  );

endmodule

`default_nettype wire

/* tb/sv/rpn_stack_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_checker
// Watches the token and result channels of the RPN stack evaluator. It keeps
// its own Q16.16 operand stack, works out the result of every accepted token
// and compares each result beat, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------

module rpn_stack_checker
  import rpn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] operand_value,
  input  wire logic        done,
  input  wire logic [31:0] top_value,
  input  wire logic [7:0]  stack_depth,
  input  wire logic [1:0]  error_code,
  input  wire logic        drain_done,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output int               full_hits,
  output int               empty_hits,
  output int               divz_hits,
  output int               peak_depth
);

  localparam longint Q_ONE     = 65536;
  localparam longint SAT_HI    = 2147483647;
  localparam longint SAT_LO    = -SAT_HI - 1;
  localparam int     PRINT_CAP = 40;

  typedef struct {
    int          seq;
    logic [2:0]  kind;
    logic [31:0] top;
    logic [7:0]  depth;
    logic [1:0]  err;
  } stack_result_t;

  logic [31:0]   stack_mem [STACK_DEPTH];
  int            depth_now;
  logic [1:0]    fault;
  int            token_seq;
  bit            leftover_seen;
  stack_result_t expected_results [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked       = 0;
    full_hits     = 0;
    empty_hits    = 0;
    divz_hits     = 0;
    peak_depth    = 0;
    depth_now     = 0;
    token_seq     = 0;
    leftover_seen = 1'b0;
  end

  task automatic report(input string msg);
    // Printing stops after a while so a broken block cannot flood the log.
    if (fail_count < PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic longint clamp_q(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic void push_entry(input longint v);
    if (depth_now < STACK_DEPTH) begin
      stack_mem[depth_now] = v[31:0];
      depth_now++;
    end else begin
      fault = ERR_FULL;
    end
  endfunction

  // A pop from an empty stack gives 0 and flags the empty error, unless an
  // error is already set for this token.
  function automatic longint pop_entry();
    if (depth_now > 0) begin
      depth_now--;
      return longint'($signed(stack_mem[depth_now]));
    end
    if (fault == ERR_NONE) fault = ERR_EMPTY;
    return 0;
  endfunction

  function automatic stack_result_t eval_token(input logic [2:0] k, input logic [31:0] v);
    stack_result_t r;
    longint lhs;
    longint rhs;
    longint ilhs;
    longint irhs;
    fault = ERR_NONE;
    case (k)
      KIND_PUSH: push_entry(longint'($signed(v)));
      KIND_ADD: begin
        rhs = pop_entry();
        lhs = pop_entry();
        push_entry(clamp_q(lhs + rhs));
      end
      KIND_SUB: begin
        rhs = pop_entry();
        lhs = pop_entry();
        push_entry(clamp_q(lhs - rhs));
      end
      KIND_MUL: begin
        rhs = pop_entry();
        lhs = pop_entry();
        push_entry(clamp_q((lhs * rhs) / Q_ONE));
      end
      KIND_DIV: begin
        rhs = pop_entry();
        // A zero divisor leaves the right operand popped and pushes nothing.
        if (rhs == 0) begin
          fault = ERR_DIVZ;
        end else begin
          lhs = pop_entry();
          push_entry(clamp_q((lhs * Q_ONE) / rhs));
        end
      end
      KIND_REM: begin
        rhs  = pop_entry();
        irhs = rhs / Q_ONE;
        // Any divisor below 1.0 in magnitude truncates to zero.
        if (irhs == 0) begin
          fault = ERR_DIVZ;
        end else begin
          lhs  = pop_entry();
          ilhs = lhs / Q_ONE;
          push_entry(clamp_q((ilhs % irhs) * Q_ONE));
        end
      end
      default: ;
    endcase
    r.seq   = token_seq;
    r.kind  = k;
    r.top   = (depth_now > 0) ? stack_mem[depth_now - 1] : '0;
    r.depth = depth_now[7:0];
    r.err   = fault;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    stack_result_t want;
    stack_result_t got_exp;
    if (rst) begin
      depth_now = 0;
      expected_results.delete();
    end else begin
      // The result beat belongs to an earlier token, so it is checked first.
      if (done) begin
        if (expected_results.size() == 0) begin
          report($sformatf("result beat with no token waiting: top %h depth %0d err %0d",
                           top_value, stack_depth, error_code));
        end else begin
          got_exp = expected_results.pop_front();
          checked++;
          if (top_value !== got_exp.top)
            report($sformatf("token %0d kind %0d top_value exp %h got %h",
                             got_exp.seq, got_exp.kind, got_exp.top, top_value));
          if (stack_depth !== got_exp.depth)
            report($sformatf("token %0d kind %0d stack_depth exp %0d got %0d",
                             got_exp.seq, got_exp.kind, got_exp.depth, stack_depth));
          if (error_code !== got_exp.err)
            report($sformatf("token %0d kind %0d error_code exp %0d got %0d",
                             got_exp.seq, got_exp.kind, got_exp.err, error_code));
        end
      end
      if (start && !busy) begin
        want = eval_token(kind, operand_value);
        token_seq++;
        case (want.err)
          ERR_FULL:  full_hits++;
          ERR_EMPTY: empty_hits++;
          ERR_DIVZ:  divz_hits++;
          default: ;
        endcase
        if (depth_now > peak_depth) peak_depth = depth_now;
        expected_results.push_back(want);
      end
      if (drain_done && !leftover_seen) begin
        leftover_seen = 1'b1;
        if (expected_results.size() != 0)
          report($sformatf("%0d expected results never arrived", expected_results.size()));
      end
    end
    pending = expected_results.size();
  end

endmodule

/* tb/sv/rpn_stack_evaluator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_tb
// Drives tokens into the RPN stack evaluator: a short directed run over the
// saturation, empty-stack and zero-divisor corners, then random expressions,
// fill and drain bursts and noise, with random idle gaps. A checker module
// predicts and compares every result; this top gives the verdict.
// ----------------------------------------------------------------------------

module rpn_stack_evaluator_tb;
  import rpn_pkg::*;

  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam int         RANDOM_ITEMS = 2000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        start         = 1'b0;
  logic [2:0]  kind          = KIND_PUSH;
  logic [31:0] operand_value = '0;
  logic        drain_done    = 1'b0;
  logic        busy;
  logic        done;
  logic [31:0] top_value;
  logic [7:0]  stack_depth;
  logic [1:0]  error_code;

  int fail_count;
  int pending;
  int checked;
  int full_hits;
  int empty_hits;
  int divz_hits;
  int peak_depth;

  int tokens_sent    = 0;
  int directed_count = 0;
  int depth_guess    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rpn_stack_evaluator i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .operand_value (operand_value),
    .done          (done),
    .top_value     (top_value),
    .stack_depth   (stack_depth),
    .error_code    (error_code)
  );

  rpn_stack_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .operand_value (operand_value),
    .done          (done),
    .top_value     (top_value),
    .stack_depth   (stack_depth),
    .error_code    (error_code),
    .drain_done    (drain_done),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .full_hits     (full_hits),
    .empty_hits    (empty_hits),
    .divz_hits     (divz_hits),
    .peak_depth    (peak_depth)
  );

  function automatic int idle_len(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] pick_operand();
    int sel;
    int iv;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      2: begin
        iv = $urandom_range(0, 100) - 50;
        return 32'(iv <<< 16);
      end
      3: begin
        // Magnitude below 1.0: truncates to a zero divisor for remainder.
        iv = $urandom_range(0, 65535);
        return ($urandom_range(0, 1) != 0) ? 32'(-iv) : 32'(iv);
      end
      4, 5: begin
        iv = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        return 32'(iv);
      end
      default: begin
        iv = ($urandom_range(0, 2000) - 1000) * 65536 + $urandom_range(0, 65535);
        return 32'(iv);
      end
    endcase
  endfunction

  // Start may go high while the block is still busy; the beat is taken at the
  // first edge where busy is low.
  task automatic send_token(input logic [2:0] k, input logic [31:0] v, input int gap);
    start         <= 1'b1;
    kind          <= k;
    operand_value <= v;
    do @(posedge clk); while (busy);
    tokens_sent++;
    if (k == KIND_PUSH) begin
      if (depth_guess < STACK_DEPTH) depth_guess++;
    end else if (k != KIND_SPARE_A && k != KIND_SPARE_B) begin
      depth_guess = (depth_guess >= 2) ? depth_guess - 1 : 0;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    logic [2:0]  dk [$];
    logic [31:0] dv [$];
    // Operations on an empty stack, including both zero-divisor paths.
    dk = '{KIND_ADD, KIND_DIV, KIND_REM, KIND_SUB, KIND_MUL, KIND_DIV,
           KIND_SPARE_A, KIND_SPARE_B};
    dv = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0};
    // Saturating add, subtract, multiply and divide.
    dk.push_back(KIND_PUSH); dv.push_back(32'h7FFF_FFFF);
    dk.push_back(KIND_PUSH); dv.push_back(32'h7FFF_FFFF);
    dk.push_back(KIND_ADD);  dv.push_back(32'h0);
    dk.push_back(KIND_PUSH); dv.push_back(32'h8000_0000);
    dk.push_back(KIND_PUSH); dv.push_back(32'h0001_0000);
    dk.push_back(KIND_SUB);  dv.push_back(32'h0);
    dk.push_back(KIND_PUSH); dv.push_back(32'h7FFF_FFFF);
    dk.push_back(KIND_MUL);  dv.push_back(32'h0);
    dk.push_back(KIND_PUSH); dv.push_back(32'h0000_0001);
    dk.push_back(KIND_DIV);  dv.push_back(32'h0);
    // Remainder of -7.5 by 2.25, then by a divisor just under 1.0.
    dk.push_back(KIND_PUSH); dv.push_back(32'hFFF8_8000);
    dk.push_back(KIND_PUSH); dv.push_back(32'h0002_4000);
    dk.push_back(KIND_REM);  dv.push_back(32'h0);
    dk.push_back(KIND_PUSH); dv.push_back(32'h0000_FFFF);
    dk.push_back(KIND_REM);  dv.push_back(32'h0);
    dk.push_back(KIND_PUSH); dv.push_back(32'h0);
    dk.push_back(KIND_DIV);  dv.push_back(32'h0);
    foreach (dk[i]) send_token(dk[i], dv[i], idle_len(1'b0));
    directed_count = dk.size();
  endtask

  task automatic run_random();
    int  mode;
    int  len;
    bit  quiet;
    int  done_items;
    logic [2:0] k;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      mode  = $urandom_range(0, 19);
      quiet = ($urandom_range(0, 3) == 0);
      if (mode == 0) begin
        // Fill past the top to hit the full-stack drop.
        len = STACK_DEPTH + $urandom_range(2, 12);
        repeat (len) send_token(KIND_PUSH, pick_operand(), idle_len(quiet));
      end else if (mode == 1) begin
        // Drain with a burst of operators, which may run past empty.
        len = $urandom_range(20, 150);
        repeat (len) send_token(3'($urandom_range(KIND_ADD, KIND_REM)), $urandom(),
                                idle_len(quiet));
      end else if (mode <= 3) begin
        len = $urandom_range(5, 20);
        repeat (len) send_token(3'($urandom_range(0, 7)), $urandom(), idle_len(quiet));
      end else begin
        // Well-formed expressions: keep at least two operands under every op.
        len = $urandom_range(30, 60);
        repeat (len) begin
          if (depth_guess < 2 || (depth_guess < 100 && $urandom_range(0, 99) < 52))
            k = KIND_PUSH;
          else
            k = 3'($urandom_range(KIND_ADD, KIND_REM));
          send_token(k, pick_operand(), idle_len(quiet));
        end
      end
      done_items += len;
    end
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    start <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 500) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Ran %0d tokens (%0d directed), checked %0d results, deepest stack %0d.",
             tokens_sent, directed_count, checked, peak_depth);
    $display("Error cases hit: stack full %0d, empty pop %0d, division by zero %0d.",
             full_hits, empty_hits, divz_hits);
    if (fail_count == 0) begin
      $display("rpn_stack_evaluator_tb passed");
    end else begin
      $display("rpn_stack_evaluator_tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("rpn_stack_evaluator_tb failed");
    $finish;
  end

endmodule
